@@ hdl/snks_pkg.sv @@
package snks_pkg;

   // Table geometry.
   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed widths of the request and response fields.
   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 7;

   // Operation codes of a request.
   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // Status codes of a response.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

endpackage

@@ hdl/snks_req_if.sv @@
interface snks_req_if import snks_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;

   modport source (output valid, operation, key, value, input ready);
   modport sink   (input valid, operation, key, value, output ready);
endinterface

@@ hdl/snks_rsp_if.sv @@
interface snks_rsp_if import snks_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic                hit;
   logic [VALUE_W-1:0]  found_value;
   logic [SLOT_W-1:0]   entries_now;

   modport source (output valid, status, slot, hit, found_value, entries_now, input ready);
   modport sink   (input valid, status, slot, hit, found_value, entries_now, output ready);
endinterface

@@ hdl/snks_ram.sv @@
module snks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ hdl/sorted_node_key_store_core.sv @@
// Channel   Direction  Transfer             Payload
// req_bus   in         valid & ready        operation, key, value
// rsp_bus   out        valid & ready        status, slot, hit, found_value, entries_now
// csr_*     in         csr_wr_en            key_is_signed
//
// After a request is accepted, the binary search issues its reads, at most
// ceil(log2(entries + 1)), through the single read port of the entry RAM; the request is
// then decided, and a successful insert or remove moves entries (one read and one write
// per move) before the response is handed over; a lookup or a failed request moves none.
// Reset clears the entry count and the mode; the RAM needs no clearing pass.
// A request is taken while the previous response waits; its response then holds in finish.
module sorted_node_key_store_core import snks_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   snks_req_if.sink   req_bus,
   snks_rsp_if.source rsp_bus,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data
);

   localparam int ENT_W = KEY_BITS + VALUE_BITS;
   localparam logic [KEY_BITS-1:0] KEY_SIGN = {1'b1, {(KEY_BITS - 1){1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_MOVE   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]      mid_ff, mid_in;
   logic                  pend_ff, pend_in;
   logic [KEY_BITS-1:0]   cand_key_ff, cand_key_in;
   logic [VALUE_BITS-1:0] cand_val_ff, cand_val_in;
   logic                  cand_ok_ff, cand_ok_in;
   logic                  up_ff, up_in;
   logic [CNT_W-1:0]      mv_ff, mv_in;
   logic [IDX_W-1:0]      dst_ff, dst_in;
   status_type            status_ff, status_in;
   logic                  hit_ff, hit_in;
   logic [VALUE_BITS-1:0] fval_ff, fval_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  signed_ff, signed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0]    rsp_fval_ff, rsp_fval_in;
   logic [SLOT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                  rsp_load;
   logic                  ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0]      ram_wr_data, ram_rd_data;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  srch_less;
   logic [CNT_W-1:0]      srch_lo, srch_hi;
   logic [CNT_W:0]        srch_sum;
   logic [IDX_W-1:0]      srch_mid;
   logic                  hit_now;
   logic                  mv_issue;
   logic [IDX_W-1:0]      mv_src;
   logic [CNT_W:0]        mv_next;

   // Key and value share one RAM word, key in the upper bits.
   snks_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key = ram_rd_data[ENT_W-1 -: KEY_BITS];
   assign rd_val = ram_rd_data[VALUE_BITS-1:0];

   // Signed mode flips the sign bit so that an unsigned compare orders the keys.
   assign srch_less = (rd_key ^ (signed_ff ? KEY_SIGN : '0)) <
                      (key_ff ^ (signed_ff ? KEY_SIGN : '0));

   // One binary search step: narrow the window with the returned entry.
   assign srch_lo  = (pend_ff && srch_less) ? CNT_W'(mid_ff) + CNT_W'(1) : lo_ff;
   assign srch_hi  = (pend_ff && !srch_less) ? CNT_W'(mid_ff) : hi_ff;
   assign srch_sum = {1'b0, srch_lo} + {1'b0, srch_hi};
   assign srch_mid = IDX_W'(srch_sum >> 1);

   // The last entry that bounded the window from above sits at the lower bound.
   assign hit_now = cand_ok_ff && (cand_key_ff == key_ff);

   // Entry moves: upward copies mv-1 to mv, downward copies mv+1 to mv.
   assign mv_next  = {1'b0, mv_ff} + (CNT_W + 1)'(1);
   assign mv_issue = up_ff ? (mv_ff > lo_ff) : (mv_next < {1'b0, count_ff});
   assign mv_src   = up_ff ? IDX_W'(mv_ff - CNT_W'(1)) : IDX_W'(mv_next);

   // Sequencer: search, decide, move entries, then hand over the response.
   always_comb begin
      st_in       = st_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      pend_in     = pend_ff;
      cand_key_in = cand_key_ff;
      cand_val_in = cand_val_ff;
      cand_ok_in  = cand_ok_ff;
      up_in       = up_ff;
      mv_in       = mv_ff;
      dst_in      = dst_ff;
      status_in   = status_ff;
      hit_in      = hit_ff;
      fval_in     = fval_ff;
      count_in    = count_ff;
      rsp_load    = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = srch_mid;
      ram_wr_en   = 1'b0;
      ram_wr_addr = IDX_W'(lo_ff);
      ram_wr_data = {key_ff, val_ff};

      case (st_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in      = req_bus.operation;
               key_in     = KEY_BITS'(req_bus.key);
               val_in     = VALUE_BITS'(req_bus.value);
               lo_in      = '0;
               hi_in      = count_ff;
               pend_in    = 1'b0;
               cand_ok_in = 1'b0;
               st_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            lo_in = srch_lo;
            hi_in = srch_hi;
            if (pend_ff && !srch_less) begin
               cand_key_in = rd_key;
               cand_val_in = rd_val;
               cand_ok_in  = 1'b1;
            end
            if (srch_lo < srch_hi) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = srch_mid;
               mid_in      = srch_mid;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               st_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            hit_in    = hit_now;
            fval_in   = hit_now ? cand_val_ff : '0;
            status_in = STATUS_OK;
            pend_in   = 1'b0;
            case (op_ff)
               OP_INSERT: begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     st_in     = ST_FINISH;
                  end else begin
                     up_in = 1'b1;
                     mv_in = count_ff;
                     st_in = ST_MOVE;
                  end
               end
               OP_REMOVE: begin
                  if (!hit_now) begin
                     status_in = STATUS_NOT_FOUND;
                     fval_in   = '0;
                     st_in     = ST_FINISH;
                  end else begin
                     up_in = 1'b0;
                     mv_in = lo_ff;
                     st_in = ST_MOVE;
                  end
               end
               default: begin
                  st_in = ST_FINISH;
               end
            endcase
         end
         ST_MOVE: begin
            // Write back the entry read in the previous cycle.
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (mv_issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = mv_src;
               dst_in      = IDX_W'(mv_ff);
               mv_in       = up_ff ? mv_ff - CNT_W'(1) : CNT_W'(mv_next);
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (up_ff) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = IDX_W'(lo_ff);
                     ram_wr_data = {key_ff, val_ff};
                     count_in    = count_ff + CNT_W'(1);
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                  end
                  st_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Response register and configuration.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_fval_in   = rsp_fval_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_slot_in   = SLOT_W'(lo_ff);
         rsp_hit_in    = hit_ff;
         rsp_fval_in   = VALUE_W'(fval_ff);
         rsp_count_in  = SLOT_W'(count_ff);
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      signed_in = csr_wr_en ? csr_wr_data : signed_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         signed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         signed_ff    <= signed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      cand_key_ff   <= cand_key_in;
      cand_val_ff   <= cand_val_in;
      cand_ok_ff    <= cand_ok_in;
      up_ff         <= up_in;
      mv_ff         <= mv_in;
      dst_ff        <= dst_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      fval_ff       <= fval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_fval_ff   <= rsp_fval_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_bus.ready       = (st_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.slot        = rsp_slot_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.found_value = rsp_fval_ff;
   assign rsp_bus.entries_now = rsp_count_ff;

   // A move never reads the entry it writes in the same cycle.
   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("entry RAM read and write hit the same entry");

   // The entry count stays within the table.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // The search window has closed by the time the operation is decided.
   a_search_closed: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DECIDE) |-> (lo_ff == hi_ff && !pend_ff))
      else $error("search ended with an open window");

   // A full report is only given for a full table.
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == STATUS_FULL) |-> (count_ff == CNT_W'(CAPACITY)))
      else $error("table full reported below capacity");

   // An accepted request starts its search in the next cycle.
   a_accept_starts_search: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (st_ff == ST_SEARCH))
      else $error("accepted request did not start a search");

endmodule
